// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the percent codec.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is not checked while the reset is high.
`define ASSERT_DIS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/pcodec_pkg.sv
// Package of the percent codec: payload types, codes, constants and byte helpers.
// No dependencies.
`timescale 1ns / 1ps

package pcodec_pkg;

   localparam logic [7:0] PCT_CHAR            = 8'h25;
   localparam logic       MODE_ENCODE         = 1'b0;
   localparam logic       MODE_DECODE         = 1'b1;
   localparam int         QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]       count;
      logic [2:0][7:0]  bytes;
      logic             last;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } queue_head_type;

   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = 5'd16;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = {1'b0, b[3:0]};
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         v = {1'b0, b[3:0] + 4'd9};
      end
      return v;
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
   endfunction

endpackage

// File: rtl/pcodec_queue.sv
// Job queue between the front and the back of the percent codec.
// Depends on pcodec_pkg.
`timescale 1ns / 1ps

module pcodec_queue #(
   parameter int DEPTH = pcodec_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pcodec_pkg::job_type        push_job,
   output logic                       full,
   input  logic                       pop,
   output pcodec_pkg::queue_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pcodec_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = entry_ff[rd_ptr_ff];

endmodule

// File: rtl/pcodec_front.sv
// Front of the percent codec: mode register, decode escape tracking and job building.
// Depends on pcodec_pkg.
`timescale 1ns / 1ps

module pcodec_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pcodec_pkg::req_payload_type req_payload,
   input  logic                        csr_valid,
   input  logic                        csr_data,
   input  logic                        queue_full,
   output logic                        push,
   output pcodec_pkg::job_type         push_job
);

   localparam logic [1:0] STAGE_IDLE  = 2'd0;
   localparam logic [1:0] STAGE_PCT   = 2'd1;
   localparam logic [1:0] STAGE_DIGIT = 2'd2;

   logic       mode_ff;
   logic [1:0] stage_ff, stage_in;
   logic [7:0] digit_ff, digit_in;
   logic [7:0] b;
   logic       last;
   logic [4:0] v;
   logic [4:0] hv;
   logic       vok;
   logic       pct_hold;
   logic       accept;
   logic [1:0] n;

   assign b        = req_payload.in_byte;
   assign last     = req_payload.in_last;
   assign v        = pcodec_pkg::hex_value(b);
   assign hv       = pcodec_pkg::hex_value(digit_ff);
   assign vok      = !v[4];
   assign pct_hold = (b == pcodec_pkg::PCT_CHAR) && !last;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      n          = 2'd0;
      push_job   = '0;
      stage_in   = stage_ff;
      digit_in   = digit_ff;
      if (mode_ff == pcodec_pkg::MODE_ENCODE) begin
         if (pcodec_pkg::is_alnum(b)) begin
            n                 = 2'd1;
            push_job.bytes[0] = b;
         end else begin
            n                 = 2'd3;
            push_job.bytes[0] = pcodec_pkg::PCT_CHAR;
            push_job.bytes[1] = pcodec_pkg::hex_char(b[7:4]);
            push_job.bytes[2] = pcodec_pkg::hex_char(b[3:0]);
         end
      end else begin
         unique case (stage_ff)
            STAGE_PCT: begin
               if (vok && !last) begin
                  stage_in = STAGE_DIGIT;
                  digit_in = b;
               end else if (vok || !pct_hold) begin
                  n                 = 2'd2;
                  push_job.bytes[0] = pcodec_pkg::PCT_CHAR;
                  push_job.bytes[1] = b;
                  stage_in          = STAGE_IDLE;
               end else begin
                  n                 = 2'd1;
                  push_job.bytes[0] = pcodec_pkg::PCT_CHAR;
                  stage_in          = STAGE_PCT;
               end
            end
            STAGE_DIGIT: begin
               digit_in = 8'h00;
               if (vok) begin
                  n                 = 2'd1;
                  push_job.bytes[0] = {hv[3:0], v[3:0]};
                  stage_in          = STAGE_IDLE;
               end else if (pct_hold) begin
                  n                 = 2'd2;
                  push_job.bytes[0] = pcodec_pkg::PCT_CHAR;
                  push_job.bytes[1] = digit_ff;
                  stage_in          = STAGE_PCT;
               end else begin
                  n                 = 2'd3;
                  push_job.bytes[0] = pcodec_pkg::PCT_CHAR;
                  push_job.bytes[1] = digit_ff;
                  push_job.bytes[2] = b;
                  stage_in          = STAGE_IDLE;
               end
            end
            default: begin
               if (pct_hold) begin
                  stage_in = STAGE_PCT;
               end else begin
                  n                 = 2'd1;
                  push_job.bytes[0] = b;
                  stage_in          = STAGE_IDLE;
               end
            end
         endcase
      end
      if (last) begin
         stage_in = STAGE_IDLE;
         digit_in = 8'h00;
      end
      push_job.count = n;
      push_job.last  = last;
   end

   assign push = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= pcodec_pkg::MODE_ENCODE;
         stage_ff <= STAGE_IDLE;
         digit_ff <= 8'h00;
      end else if (csr_valid) begin
         mode_ff  <= csr_data;
         stage_ff <= STAGE_IDLE;
         digit_ff <= 8'h00;
      end else if (accept) begin
         stage_ff <= stage_in;
         digit_ff <= digit_in;
      end
   end

endmodule

// File: rtl/pcodec_back.sv
// Back of the percent codec: sends the bytes of each queued job through the output register.
// Depends on pcodec_pkg.
`timescale 1ns / 1ps

module pcodec_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pcodec_pkg::queue_head_type  head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pcodec_pkg::rsp_payload_type rsp_payload
);

   logic [1:0]                  idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pcodec_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic                        load;
   logic                        final_byte;

   assign load       = head.valid && (!rsp_valid_ff || rsp_ready);
   assign final_byte = (idx_ff == head.job.count - 2'd1);
   assign pop        = load && final_byte;

   always_comb begin
      idx_in                  = idx_ff;
      rsp_payload_in          = rsp_payload_ff;
      rsp_valid_in            = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.out_byte = head.job.bytes[idx_ff];
         rsp_payload_in.out_last = head.job.last && final_byte;
         idx_in                  = final_byte ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: rtl/percent_codec_core.sv
// Path: input beat -> job queue -> single output register. Throughput: one result beat
// per cycle from the output register unless rsp_ready is low; an input byte makes zero
// to three result beats, so an escaped byte in encode mode holds the back for three
// beats, while the front takes a beat each cycle while the job queue has room.
// Reset: synchronous; mode returns to encode, pending escape bytes, queue and output clear.
`timescale 1ns / 1ps

module percent_codec_core #(
   parameter int QUEUE_DEPTH = pcodec_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pcodec_pkg::req_payload_type req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pcodec_pkg::rsp_payload_type rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_data
);

   logic                       queue_full;
   logic                       push;
   logic                       pop;
   pcodec_pkg::job_type        push_job;
   pcodec_pkg::queue_head_type head;

   assign csr_ready = 1'b1;

   pcodec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   pcodec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   pcodec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/pcodec_checker.sv
// Port checker of the percent codec and its bind to the top level.
// Depends on pcodec_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcodec_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input pcodec_pkg::rsp_payload_type rsp_payload,
   input logic                        csr_ready
);

   // A result beat that is not taken stays offered.
   `ASSERT_DIS(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   // A result beat that is not taken keeps its payload.
   `ASSERT_DIS(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_payload))
   // Reset leaves no result beat pending.
   `ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)
   // The job queue is empty after reset, so the input side is open.
   `ASSERT_ALWAYS(a_req_reset, clock, reset |=> req_ready)
   // The mode register takes a write in any cycle.
   `ASSERT_DIS(a_csr_ready, clock, reset, csr_ready)

endmodule

bind percent_codec_core pcodec_checker u_checker (.*);

// File: tb/sv/percent_codec_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of percent_codec_core: drives byte streams in encode and decode mode
// under random stalls and compares every result beat with a prediction kept in a small class.
// Depends on pcodec_pkg and percent_codec_core.

module percent_codec_core_tb;

   localparam int RX_HOLD_CYCLES = 120;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_BEATS    = 54;
   localparam int IDLE_PERCENT   = 35;
   localparam int NOT_HEX        = 16;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;

   typedef enum logic [1:0] {STAGE_NONE, STAGE_PCT, STAGE_PCT_DIGIT} escape_stage_type;

   class escape_ledger;
      logic                        mode;
      escape_stage_type            stage;
      logic [7:0]                  held_digit;
      pcodec_pkg::rsp_payload_type due[$];
      pcodec_pkg::rsp_payload_type step[$];
      int unsigned                 errors;
      int unsigned                 matched;

      function new();
         mode = pcodec_pkg::MODE_ENCODE;
         stage = STAGE_NONE;
         held_digit = '0;
         errors = 0;
         matched = 0;
      endfunction

      function void set_mode(logic m);
         mode = m;
         stage = STAGE_NONE;
         held_digit = '0;
      endfunction

      function int digit_value(logic [7:0] b);
         if (b >= CHAR_ZERO && b <= CHAR_NINE) return int'(b - CHAR_ZERO);
         if (b >= CHAR_UP_A && b <= CHAR_UP_F) return int'(b - CHAR_UP_A) + 10;
         if (b >= CHAR_LOW_A && b <= CHAR_LOW_F) return int'(b - CHAR_LOW_A) + 10;
         return NOT_HEX;
      endfunction

      function bit is_word_char(logic [7:0] b);
         return (b >= CHAR_ZERO && b <= CHAR_NINE) || (b >= CHAR_UP_A && b <= CHAR_UP_Z) ||
                (b >= CHAR_LOW_A && b <= CHAR_LOW_Z);
      endfunction

      function logic [7:0] nibble_char(logic [3:0] n);
         return (n < 4'd10) ? CHAR_ZERO + 8'(n) : CHAR_UP_A + 8'(n) - 8'd10;
      endfunction

      function void emit(logic [7:0] b);
         pcodec_pkg::rsp_payload_type r;
         r.out_byte = b;
         r.out_last = 1'b0;
         step.insert(step.size(), r);
      endfunction

      function void scan_fresh(logic [7:0] b, logic last);
         if (b == pcodec_pkg::PCT_CHAR && !last) begin
            stage = STAGE_PCT;
         end else begin
            emit(b);
         end
      endfunction

      function void note_input(pcodec_pkg::req_payload_type p);
         int         v;
         logic [7:0] d;
         step.delete();
         v = digit_value(p.in_byte);
         if (mode == pcodec_pkg::MODE_ENCODE) begin
            if (is_word_char(p.in_byte)) begin
               emit(p.in_byte);
            end else begin
               emit(pcodec_pkg::PCT_CHAR);
               emit(nibble_char(p.in_byte[7:4]));
               emit(nibble_char(p.in_byte[3:0]));
            end
         end else begin
            case (stage)
               STAGE_PCT: begin
                  stage = STAGE_NONE;
                  if (v != NOT_HEX && !p.in_last) begin
                     stage = STAGE_PCT_DIGIT;
                     held_digit = p.in_byte;
                  end else if (v != NOT_HEX) begin
                     emit(pcodec_pkg::PCT_CHAR);
                     emit(p.in_byte);
                  end else begin
                     emit(pcodec_pkg::PCT_CHAR);
                     scan_fresh(p.in_byte, p.in_last);
                  end
               end
               STAGE_PCT_DIGIT: begin
                  d = held_digit;
                  stage = STAGE_NONE;
                  held_digit = '0;
                  if (v != NOT_HEX) begin
                     emit(8'(digit_value(d) * 16 + v));
                  end else begin
                     emit(pcodec_pkg::PCT_CHAR);
                     emit(d);
                     scan_fresh(p.in_byte, p.in_last);
                  end
               end
               default: begin
                  stage = STAGE_NONE;
                  scan_fresh(p.in_byte, p.in_last);
               end
            endcase
         end
         if (p.in_last) begin
            stage = STAGE_NONE;
            held_digit = '0;
            if (step.size() > 0) step[step.size() - 1].out_last = 1'b1;
         end
         foreach (step[i]) due.insert(due.size(), step[i]);
      endfunction

      function void check_result(pcodec_pkg::rsp_payload_type got);
         pcodec_pkg::rsp_payload_type want;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected, actual byte %02h last %0b",
                     $time, got.out_byte, got.out_last);
            return;
         end
         want = due.pop_front();
         matched++;
         if (got.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.out_byte, got.out_byte);
         end
         if (got.out_last !== want.out_last) begin
            errors++;
            $display("%0t: out_last expected %0b actual %0b",
                     $time, want.out_last, got.out_last);
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   pcodec_pkg::req_payload_type req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   pcodec_pkg::rsp_payload_type rsp_payload;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic                        csr_data = 1'b0;

   bit              quiet = 1'b0;
   int unsigned     hold_asked = 0;
   int unsigned     hold_taken = 0;
   int unsigned     hold_left = 0;
   int unsigned     stuck_cycles = 0;
   int unsigned     beats_sent = 0;
   int unsigned     mode_writes = 0;
   escape_ledger    ledger;

   percent_codec_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_taken) begin
         hold_taken <= hold_asked;
         hold_left <= RX_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ledger.check_result(rsp_payload);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, stuck_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic last);
      pcodec_pkg::req_payload_type p;
      p.in_byte = b;
      p.in_last = last;
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ledger.note_input(p);
      beats_sent++;
   endtask

   task automatic rest_sender();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (ledger.due.size() != 0);
   endtask

   task automatic write_mode(input logic m);
      rest_sender();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ledger.set_mode(m);
      mode_writes++;
   endtask

   task automatic send_text(input string s, input logic last_at_end);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(s[i], last_at_end && (i == s.len() - 1));
      end
   endtask

   function automatic logic [7:0] hex_pick();
      int n;
      n = $urandom_range(15);
      if (n < 10) return CHAR_ZERO + 8'(n);
      return (($urandom_range(1) == 1) ? CHAR_LOW_A : CHAR_UP_A) + 8'(n - 10);
   endfunction

   function automatic logic [7:0] word_pick();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (!ledger.is_word_char(b));
      return b;
   endfunction

   initial begin
      logic [7:0] msg[$];
      logic       cur_mode;
      int         pick;
      int         pieces;
      int         sent_in_phase;
      bit         paused;
      ledger = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Encode mode straight out of reset: word characters, extremes and escaped bytes.
      send_text("Az09", 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(pcodec_pkg::PCT_CHAR, 1'b0);
      send_beat(8'h5B, 1'b1);

      // Decode mode: good escapes of both cases, broken escapes and flushes at message end.
      write_mode(pcodec_pkg::MODE_DECODE);
      send_text("%41%6a%G%4%41", 1'b0);
      send_text("%4%", 1'b1);
      send_text("%4", 1'b1);

      // A mode write drops a pending escape.
      send_beat(pcodec_pkg::PCT_CHAR, 1'b0);
      write_mode(pcodec_pkg::MODE_DECODE);
      send_beat(CHAR_UP_A + 8'd1, 1'b1);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < 4) begin
            cur_mode = (phase % 2 == 1) ? pcodec_pkg::MODE_DECODE : pcodec_pkg::MODE_ENCODE;
         end else begin
            cur_mode = ($urandom_range(1) == 1) ? pcodec_pkg::MODE_DECODE :
                                                  pcodec_pkg::MODE_ENCODE;
         end
         write_mode(cur_mode);
         quiet <= (phase == 2);
         if (phase == 3) hold_asked <= hold_asked + 1;
         sent_in_phase = 0;
         paused = 1'b0;
         while (sent_in_phase < PHASE_BEATS) begin
            msg.delete();
            pieces = $urandom_range(1, 5);
            for (int k = 0; k < pieces; k++) begin
               pick = $urandom_range(99);
               if (cur_mode == pcodec_pkg::MODE_ENCODE) begin
                  msg.insert(msg.size(), (pick < 50) ? word_pick() : 8'($urandom_range(255)));
               end else if (pick < 50) begin
                  msg.insert(msg.size(), pcodec_pkg::PCT_CHAR);
                  msg.insert(msg.size(), hex_pick());
                  msg.insert(msg.size(), hex_pick());
               end else if (pick < 70) begin
                  msg.insert(msg.size(), word_pick());
               end else if (pick < 80) begin
                  msg.insert(msg.size(), 8'($urandom_range(255)));
               end else if (pick < 90) begin
                  msg.insert(msg.size(), pcodec_pkg::PCT_CHAR);
                  msg.insert(msg.size(), hex_pick());
                  msg.insert(msg.size(), 8'($urandom_range(255)));
               end else if (pick < 95) begin
                  msg.insert(msg.size(), pcodec_pkg::PCT_CHAR);
                  msg.insert(msg.size(), 8'($urandom_range(255)));
               end else begin
                  msg.insert(msg.size(), pcodec_pkg::PCT_CHAR);
               end
            end
            foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
            sent_in_phase += msg.size();
            if (phase == 5 && !paused && sent_in_phase >= PHASE_BEATS / 2) begin
               rest_sender();
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      rest_sender();
      wait_drained();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      $display("Sent %0d input beats over %0d mode writes, both modes, with stalls on both sides;",
               beats_sent, mode_writes);
      $display("checked %0d result beats, %0d mismatches.", ledger.matched, ledger.errors);
      if (ledger.errors == 0 && ledger.due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
